// File: sv/vau_pkg.sv
`timescale 1ns / 1ps

package vau_pkg;

	localparam int COMP_WIDTH = 16;
	localparam int FACTOR_WIDTH = 16;
	localparam int SQ_WIDTH = 2 * COMP_WIDTH;
	localparam int ROOT_WIDTH = COMP_WIDTH;
	localparam int REM_WIDTH = COMP_WIDTH + 2;
	localparam int Q_WIDTH = COMP_WIDTH - 1;
	localparam int SQRT_CELLS = SQ_WIDTH / 2;
	localparam int DIV_CELLS = Q_WIDTH;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_SCALE = 3'd2;
	localparam logic [2:0] OP_MAG = 3'd3;
	localparam logic [2:0] OP_NORM = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam logic [Q_WIDTH-1:0] NORM_ONE = Q_WIDTH'(1) << (COMP_WIDTH - 2);

	typedef struct packed {
		logic [2:0]                   opcode;
		logic signed [COMP_WIDTH-1:0] ax;
		logic signed [COMP_WIDTH-1:0] ay;
		logic signed [COMP_WIDTH-1:0] bx;
		logic signed [COMP_WIDTH-1:0] by;
		logic signed [FACTOR_WIDTH-1:0] factor;
	} vau_cmd_t;

	typedef struct packed {
		logic signed [COMP_WIDTH-1:0] rx;
		logic signed [COMP_WIDTH-1:0] ry;
		logic [COMP_WIDTH-1:0]        magnitude;
		logic [1:0]                   status;
	} vau_res_t;

	// item data that rides along the cell chains
	typedef struct packed {
		logic [2:0]                   opcode;
		logic signed [COMP_WIDTH-1:0] rx;
		logic signed [COMP_WIDTH-1:0] ry;
		logic [1:0]                   status;
		logic                         sx;
		logic                         sy;
		logic [COMP_WIDTH-1:0]        absx;
		logic [COMP_WIDTH-1:0]        absy;
	} vau_lane_t;

	typedef struct packed {
		logic [SQ_WIDTH-1:0]   rad;
		logic [ROOT_WIDTH-1:0] root;
		logic [REM_WIDTH-1:0]  rem;
	} vau_sq_t;

	typedef struct packed {
		logic [ROOT_WIDTH-1:0] mag;
		logic [COMP_WIDTH-1:0] remx;
		logic [COMP_WIDTH-1:0] remy;
		logic                  nbx;
		logic                  nby;
		logic [Q_WIDTH-1:0]    qx;
		logic [Q_WIDTH-1:0]    qy;
	} vau_dv_t;

	// clamp a wide signed value to the component range, flag in the top bit
	function automatic logic [COMP_WIDTH:0] sat_comp(input logic signed [SQ_WIDTH:0] v);
		logic signed [SQ_WIDTH:0] hi;
		logic signed [SQ_WIDTH:0] lo;
		hi = (SQ_WIDTH+1)'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
		lo = -(SQ_WIDTH+1)'(64'sd1 <<< (COMP_WIDTH - 1));
		if (v > hi) begin
			sat_comp = {1'b1, hi[COMP_WIDTH-1:0]};
		end else if (v < lo) begin
			sat_comp = {1'b1, lo[COMP_WIDTH-1:0]};
		end else begin
			sat_comp = {1'b0, v[COMP_WIDTH-1:0]};
		end
	endfunction

endpackage

// File: sv/vau_sqrt_cell.sv
`timescale 1ns / 1ps

module vau_sqrt_cell import vau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_in,
	input  vau_lane_t lane_in,
	input  vau_sq_t   sq_in,
	output logic      valid_out,
	output vau_lane_t lane_out,
	output vau_sq_t   sq_out
);

	logic [REM_WIDTH+1:0] cur;
	logic [REM_WIDTH+1:0] trial;
	vau_sq_t              nxt;

	// one root bit: bring down two radicand bits, try the subtract
	always_comb begin
		cur = {sq_in.rem, sq_in.rad[SQ_WIDTH-1 -: 2]};
		trial = (REM_WIDTH+2)'({sq_in.root, 2'b01});
		nxt.rad = sq_in.rad << 2;
		if (cur >= trial) begin
			nxt.rem = REM_WIDTH'(cur - trial);
			nxt.root = {sq_in.root[ROOT_WIDTH-2:0], 1'b1};
		end else begin
			nxt.rem = REM_WIDTH'(cur);
			nxt.root = {sq_in.root[ROOT_WIDTH-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		lane_out <= lane_in;
		sq_out <= nxt;
	end

endmodule

// File: sv/vau_div_cell.sv
`timescale 1ns / 1ps

module vau_div_cell import vau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_in,
	input  vau_lane_t lane_in,
	input  vau_dv_t   dv_in,
	output logic      valid_out,
	output vau_lane_t lane_out,
	output vau_dv_t   dv_out
);

	logic [COMP_WIDTH:0] tx;
	logic [COMP_WIDTH:0] ty;
	logic [COMP_WIDTH:0] m;
	vau_dv_t             nxt;

	// one quotient bit for each component against the shared magnitude
	always_comb begin
		tx = {dv_in.remx, dv_in.nbx};
		ty = {dv_in.remy, dv_in.nby};
		m = (COMP_WIDTH+1)'(dv_in.mag);
		nxt = dv_in;
		nxt.nbx = 1'b0;
		nxt.nby = 1'b0;
		if (tx >= m) begin
			nxt.remx = COMP_WIDTH'(tx - m);
			nxt.qx = {dv_in.qx[Q_WIDTH-2:0], 1'b1};
		end else begin
			nxt.remx = COMP_WIDTH'(tx);
			nxt.qx = {dv_in.qx[Q_WIDTH-2:0], 1'b0};
		end
		if (ty >= m) begin
			nxt.remy = COMP_WIDTH'(ty - m);
			nxt.qy = {dv_in.qy[Q_WIDTH-2:0], 1'b1};
		end else begin
			nxt.remy = COMP_WIDTH'(ty);
			nxt.qy = {dv_in.qy[Q_WIDTH-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		lane_out <= lane_in;
		dv_out <= nxt;
	end

endmodule

// File: sv/vector2_arith_unit.sv
`timescale 1ns / 1ps

// 2D vector unit: add, subtract, scale, magnitude and normalize on signed
// fixed-point components. A command is taken on every cycle that start is
// high (busy is always low), and each command gives exactly one result,
// flagged by a one-cycle done pulse.
// The receiver cannot stall: results must be captured on the done cycle.
// The path is built from the cell chains: two front stages (products, then sums
// and saturation), 16 square-root cells at one root bit each, 15 divide
// cells at one quotient bit each, and the output register.
module vector2_arith_unit import vau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  vau_cmd_t cmd,
	output logic     done,
	output vau_res_t res
);

	// stage 1: products and raw sums
	logic                       v_s1;
	logic [2:0]                 op_s1;
	logic signed [COMP_WIDTH-1:0] ax_s1, ay_s1;
	logic [SQ_WIDTH-1:0]        sqx_s1, sqy_s1;
	logic signed [SQ_WIDTH-1:0] px_s1, py_s1;
	logic signed [COMP_WIDTH:0] addx_s1, addy_s1, subx_s1, suby_s1;

	logic signed [SQ_WIDTH-1:0] sqx_c, sqy_c, px_c, py_c;

	assign busy = 1'b0;

	always_comb begin
		sqx_c = cmd.ax * cmd.ax;
		sqy_c = cmd.ay * cmd.ay;
		px_c = cmd.ax * cmd.factor;
		py_c = cmd.ay * cmd.factor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= cmd.opcode;
		ax_s1 <= cmd.ax;
		ay_s1 <= cmd.ay;
		sqx_s1 <= $unsigned(sqx_c);
		sqy_s1 <= $unsigned(sqy_c);
		px_s1 <= px_c;
		py_s1 <= py_c;
		addx_s1 <= (COMP_WIDTH+1)'(cmd.ax) + (COMP_WIDTH+1)'(cmd.bx);
		addy_s1 <= (COMP_WIDTH+1)'(cmd.ay) + (COMP_WIDTH+1)'(cmd.by);
		subx_s1 <= (COMP_WIDTH+1)'(cmd.ax) - (COMP_WIDTH+1)'(cmd.bx);
		suby_s1 <= (COMP_WIDTH+1)'(cmd.ay) - (COMP_WIDTH+1)'(cmd.by);
	end

	// stage 2: sum of squares, saturation of the simple operations
	logic [COMP_WIDTH:0]      satx_c, saty_c;
	logic signed [SQ_WIDTH:0] wx_c, wy_c;
	vau_lane_t                lane_c;

	always_comb begin
		case (op_s1)
			OP_ADD: begin
				wx_c = (SQ_WIDTH+1)'(addx_s1);
				wy_c = (SQ_WIDTH+1)'(addy_s1);
			end
			OP_SUB: begin
				wx_c = (SQ_WIDTH+1)'(subx_s1);
				wy_c = (SQ_WIDTH+1)'(suby_s1);
			end
			default: begin
				wx_c = (SQ_WIDTH+1)'(px_s1);
				wy_c = (SQ_WIDTH+1)'(py_s1);
			end
		endcase
		satx_c = sat_comp(wx_c);
		saty_c = sat_comp(wy_c);
		lane_c.opcode = op_s1;
		lane_c.rx = satx_c[COMP_WIDTH-1:0];
		lane_c.ry = saty_c[COMP_WIDTH-1:0];
		lane_c.status = (satx_c[COMP_WIDTH] || saty_c[COMP_WIDTH]) ? ST_SAT : ST_OK;
		lane_c.sx = ax_s1[COMP_WIDTH-1];
		lane_c.sy = ay_s1[COMP_WIDTH-1];
		lane_c.absx = ax_s1[COMP_WIDTH-1] ? COMP_WIDTH'(-ax_s1) : COMP_WIDTH'(ax_s1);
		lane_c.absy = ay_s1[COMP_WIDTH-1] ? COMP_WIDTH'(-ay_s1) : COMP_WIDTH'(ay_s1);
	end

	logic      sq_v [0:SQRT_CELLS];
	vau_lane_t sq_lane [0:SQRT_CELLS];
	vau_sq_t   sq_st [0:SQRT_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else begin
			sq_v[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_lane[0] <= lane_c;
		sq_st[0].rad <= sqx_s1 + sqy_s1;
		sq_st[0].root <= '0;
		sq_st[0].rem <= '0;
	end

	// square-root chain
	genvar gi;
	generate
		for (gi = 0; gi < SQRT_CELLS; gi++) begin : g_sqrt
			vau_sqrt_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.valid_in  (sq_v[gi]),
				.lane_in   (sq_lane[gi]),
				.sq_in     (sq_st[gi]),
				.valid_out (sq_v[gi+1]),
				.lane_out  (sq_lane[gi+1]),
				.sq_out    (sq_st[gi+1])
			);
		end
	endgenerate

	// divide chain seed: numerator bits start with the absolute component value
	logic      dv_v [0:DIV_CELLS];
	vau_lane_t dv_lane [0:DIV_CELLS];
	vau_dv_t   dv_st [0:DIV_CELLS];

	always_comb begin
		dv_v[0] = sq_v[SQRT_CELLS];
		dv_lane[0] = sq_lane[SQRT_CELLS];
		dv_st[0].mag = sq_st[SQRT_CELLS].root;
		dv_st[0].remx = sq_lane[SQRT_CELLS].absx >> 1;
		dv_st[0].remy = sq_lane[SQRT_CELLS].absy >> 1;
		dv_st[0].nbx = sq_lane[SQRT_CELLS].absx[0];
		dv_st[0].nby = sq_lane[SQRT_CELLS].absy[0];
		dv_st[0].qx = '0;
		dv_st[0].qy = '0;
	end

	generate
		for (gi = 0; gi < DIV_CELLS; gi++) begin : g_div
			vau_div_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.valid_in  (dv_v[gi]),
				.lane_in   (dv_lane[gi]),
				.dv_in     (dv_st[gi]),
				.valid_out (dv_v[gi+1]),
				.lane_out  (dv_lane[gi+1]),
				.dv_out    (dv_st[gi+1])
			);
		end
	endgenerate

	// final select per opcode and output register
	vau_lane_t          fl;
	vau_dv_t            fd;
	logic [Q_WIDTH-1:0] cqx, cqy;
	vau_res_t           res_c;

	always_comb begin
		fl = dv_lane[DIV_CELLS];
		fd = dv_st[DIV_CELLS];
		cqx = (fd.qx > NORM_ONE) ? NORM_ONE : fd.qx;
		cqy = (fd.qy > NORM_ONE) ? NORM_ONE : fd.qy;
		res_c = '0;
		case (fl.opcode)
			OP_ADD, OP_SUB, OP_SCALE: begin
				res_c.rx = fl.rx;
				res_c.ry = fl.ry;
				res_c.status = fl.status;
			end
			OP_MAG: begin
				res_c.magnitude = fd.mag;
			end
			OP_NORM: begin
				if (fd.mag == '0) begin
					res_c.status = ST_ZERO;
				end else begin
					res_c.magnitude = fd.mag;
					res_c.rx = fl.sx ? -COMP_WIDTH'(cqx) : COMP_WIDTH'(cqx);
					res_c.ry = fl.sy ? -COMP_WIDTH'(cqy) : COMP_WIDTH'(cqy);
				end
			end
			default: begin
				res_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_v[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		res <= res_c;
	end

endmodule

// File: dv/vector2_arith_unit_chk.sv
`timescale 1ns / 1ps

module vector2_arith_unit_chk import vau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  vau_cmd_t cmd,
	input  logic     done,
	input  vau_res_t res,
	output int       fail_count,
	output int       pending
);

	vau_res_t expected_q[$];

	// floor square root of an unsigned value
	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint clamp_comp(input longint v, inout bit hit);
		longint hi;
		longint lo;
		hi = (64'sd1 <<< (COMP_WIDTH - 1)) - 1;
		lo = -(64'sd1 <<< (COMP_WIDTH - 1));
		if (v > hi) begin
			hit = 1;
			return hi;
		end
		if (v < lo) begin
			hit = 1;
			return lo;
		end
		return v;
	endfunction

	function automatic longint unit_comp(input longint c, input longint unsigned m);
		longint unsigned a;
		longint unsigned q;
		a = (c < 0) ? -c : c;
		q = (a << (COMP_WIDTH - 2)) / m;
		if (q > (64'd1 << (COMP_WIDTH - 2))) q = 64'd1 << (COMP_WIDTH - 2);
		return (c < 0) ? -longint'(q) : longint'(q);
	endfunction

	// expected result of one vector command
	function automatic vau_res_t vector_result(input vau_cmd_t c);
		vau_res_t r;
		longint ax, ay, bx, by, f, x, y;
		longint unsigned m;
		bit hit;
		ax = c.ax;
		ay = c.ay;
		bx = c.bx;
		by = c.by;
		f = c.factor;
		x = 0;
		y = 0;
		m = 0;
		hit = 0;
		r = '0;
		r.status = ST_OK;
		case (c.opcode)
			OP_ADD, OP_SUB, OP_SCALE: begin
				if (c.opcode == OP_ADD) begin
					x = clamp_comp(ax + bx, hit);
					y = clamp_comp(ay + by, hit);
				end else if (c.opcode == OP_SUB) begin
					x = clamp_comp(ax - bx, hit);
					y = clamp_comp(ay - by, hit);
				end else begin
					x = clamp_comp(ax * f, hit);
					y = clamp_comp(ay * f, hit);
				end
				if (hit) r.status = ST_SAT;
			end
			OP_MAG, OP_NORM: begin
				m = floor_sqrt(longint'(ax * ax + ay * ay));
				if (c.opcode == OP_NORM) begin
					if (m == 0) begin
						r.status = ST_ZERO;
					end else begin
						x = unit_comp(ax, m);
						y = unit_comp(ay, m);
					end
				end
			end
			default: begin
			end
		endcase
		r.rx = x[COMP_WIDTH-1:0];
		r.ry = y[COMP_WIDTH-1:0];
		r.magnitude = m[COMP_WIDTH-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
		fail_count++;
	endtask

	initial fail_count = 0;
	assign pending = expected_q.size();

	// predict on command transfer, compare on result strobe
	always @(posedge clk) begin
		vau_res_t e;
		if (arst_n) begin
			if (done) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					e = expected_q.pop_front();
					if (res.rx !== e.rx) report_mismatch("rx", res.rx, e.rx);
					if (res.ry !== e.ry) report_mismatch("ry", res.ry, e.ry);
					if (res.magnitude !== e.magnitude)
						report_mismatch("magnitude", res.magnitude, e.magnitude);
					if (res.status !== e.status)
						report_mismatch("status", res.status, e.status);
				end
			end
			if (start && !busy) expected_q.push_back(vector_result(cmd));
		end
	end

endmodule

// File: dv/vector2_arith_unit_tb.sv
`timescale 1ns / 1ps

module vector2_arith_unit_tb;
	import vau_pkg::*;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	vau_cmd_t cmd;
	logic     done;
	vau_res_t res;
	int       fail_count;
	int       pending;

	vector2_arith_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .res(res)
	);

	vector2_arith_unit_chk u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .res(res), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// generous limit
	initial begin
		#200000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// edge-heavy component value
	function automatic logic [15:0] pick_comp();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	// one command transfer, with optional idle cycles first
	task automatic send_cmd(input logic [2:0] op, input logic [15:0] ax, input logic [15:0] ay,
			input logic [15:0] bx, input logic [15:0] by, input logic [15:0] f, input bit idle);
		if (idle) begin
			while ($urandom_range(0, 99) < 32) begin
				start <= 0;
				@(negedge clk);
			end
		end
		start <= 1;
		cmd <= '{opcode: op, ax: ax, ay: ay, bx: bx, by: by, factor: f};
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [2:0] op;
		arst_n = 0;
		start = 0;
		cmd = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed corners
		send_cmd(OP_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h0000, 0);
		send_cmd(OP_ADD, 16'h0100, 16'hff00, 16'h0200, 16'h0300, 16'h0000, 0);
		send_cmd(OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h0000, 0);
		send_cmd(OP_SUB, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 0);
		send_cmd(OP_SCALE, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 0);
		send_cmd(OP_SCALE, 16'h8000, 16'h0001, 16'h0000, 16'h0000, 16'hffff, 0);
		send_cmd(OP_SCALE, 16'h0100, 16'hff00, 16'h0000, 16'h0000, 16'h7fff, 0);
		send_cmd(OP_SCALE, 16'h1234, 16'h4321, 16'hffff, 16'hffff, 16'h0001, 0);
		send_cmd(OP_MAG, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 0);
		send_cmd(OP_MAG, 16'h0300, 16'h0400, 16'h0000, 16'h0000, 16'h0000, 0);
		send_cmd(OP_MAG, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
		send_cmd(OP_NORM, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
		send_cmd(OP_NORM, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 0);
		send_cmd(OP_NORM, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 0);
		send_cmd(OP_NORM, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
		send_cmd(OP_NORM, 16'hfffd, 16'h0004, 16'h0000, 16'h0000, 16'h0000, 0);
		send_cmd(OP_NORM, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
		send_cmd(3'd5, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 0);
		send_cmd(3'd6, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);
		send_cmd(3'd7, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);

		// random mix; a back-to-back stretch in the middle
		for (int i = 0; i < 1850; i++) begin
			op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			send_cmd(op, pick_comp(), pick_comp(), pick_comp(), pick_comp(),
				($urandom_range(0, 1) ? 16'(int'($urandom_range(0, 8)) - 4) : pick_comp()),
				!(i >= 700 && i < 1000));
		end
		start <= 0;

		// drain
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
